// File: rtl/sp7_pkg.sv
// Shared types and constants of the seven-point stencil matrix-vector block.
// No dependencies; every other file but sp7_ram imports this package.
package sp7_pkg;

  localparam int VALUE_W   = 32;  // Q16.16 words
  localparam int COORD_W   = 4;   // cell coordinate fields
  localparam int EXTENT_W  = 5;   // extent registers
  localparam int CFG_IDX_W = 2;   // register index on the config channel
  localparam int ACC_W     = 64;  // product and accumulator width
  localparam int FRAC_W    = 16;  // fraction bits of Q16.16
  localparam int TAPS      = 7;   // stencil points
  localparam int DRAIN_CYCLES = 3;  // multiply, round, accumulate

  localparam int GRID_X_DEFAULT = 16;
  localparam int GRID_Y_DEFAULT = 16;
  localparam int GRID_Z_DEFAULT = 16;

  localparam logic [EXTENT_W-1:0] EXTENT_RESET = EXTENT_W'(16);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    TAP_C, TAP_W, TAP_E, TAP_S, TAP_N, TAP_B, TAP_T
  } tap_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE
  } st_e;

  typedef struct packed {
    logic we;
    logic re;
  } ram_req_t;

  typedef struct packed {
    logic clear;      // new compute item: clear accumulator
    logic capture;    // latch coefficients
    logic tap_valid;  // a read was issued for tap_sel this cycle
    tap_e tap_sel;
  } mac_ctl_t;

endpackage

// File: rtl/sp7_ifs.sv
// Handshake interfaces: item input, result output and config write channel.
// Depends on sp7_pkg.
interface sp7_item_if import sp7_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [VALUE_W-1:0]  vector_value;
  logic        [COORD_W-1:0]  cell_x;
  logic        [COORD_W-1:0]  cell_y;
  logic        [COORD_W-1:0]  cell_z;
  logic signed [VALUE_W-1:0]  coef_center;
  logic signed [VALUE_W-1:0]  coef_west;
  logic signed [VALUE_W-1:0]  coef_east;
  logic signed [VALUE_W-1:0]  coef_south;
  logic signed [VALUE_W-1:0]  coef_north;
  logic signed [VALUE_W-1:0]  coef_bottom;
  logic signed [VALUE_W-1:0]  coef_top;

  modport source (
    output valid, action, vector_value, cell_x, cell_y, cell_z,
           coef_center, coef_west, coef_east, coef_south, coef_north,
           coef_bottom, coef_top,
    input  ready
  );
  modport sink (
    input  valid, action, vector_value, cell_x, cell_y, cell_z,
           coef_center, coef_west, coef_east, coef_south, coef_north,
           coef_bottom, coef_top,
    output ready
  );
endinterface

interface sp7_result_if import sp7_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] product_value;

  modport source (output valid, product_value, input ready);
  modport sink   (input valid, product_value, output ready);
endinterface

interface sp7_cfg_if import sp7_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [EXTENT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/seven_point_stencil_matvec.sv
// Top level of the seven-point stencil matrix-vector block.
// Depends on sp7_pkg, sp7_ifs, sp7_ram, sp7_ctrl and sp7_mac.
//
// Load beats (action 0) write one Q16.16 vector element into the grid RAM at
// address (z*GRID_Y + y)*GRID_X + x on acceptance, and the next beat may follow
// at once. Loads with a coordinate beyond the grid are dropped.
// Compute beats (action 1) read the center cell and each in-extent neighbor
// from the same single-ported RAM, one tap slot per cycle for all seven taps,
// and return one saturated Q16.16 result beat. A compute occupies the block
// from acceptance through the accept cycle, a slot on the RAM port for each
// of the seven taps, the drain of the multiply / round / accumulate pipeline
// and the hand-over of the sum to the output register, plus any wait while
// the previous result beat is still held. No beats are taken while a result
// waits. Grid contents are undefined until loaded; there is no clearing pass
// after reset. Extent registers (reset 16) are written through the config
// channel, which is always ready; write them only when idle.
module seven_point_stencil_matvec import sp7_pkg::*; #(
  parameter int GRID_X = GRID_X_DEFAULT,
  parameter int GRID_Y = GRID_Y_DEFAULT,
  parameter int GRID_Z = GRID_Z_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sp7_cfg_if.sink     cfg,
  sp7_item_if.sink    items,
  sp7_result_if.source results
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);

  logic [EXTENT_W-1:0]       ext_x, ext_y, ext_z;
  logic                      out_valid, out_free, result_load;
  logic signed [VALUE_W-1:0] out_value, sum_sat;
  ram_req_t                  ram_req;
  logic [AW-1:0]             ram_addr;
  logic [VALUE_W-1:0]        ram_rdata;
  mac_ctl_t                  mac_ctl;
  logic signed [VALUE_W-1:0] coef_in [TAPS];

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_x <= EXTENT_RESET;
      ext_y <= EXTENT_RESET;
      ext_z <= EXTENT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EXTENT_X: ext_x <= cfg.data;
        REG_EXTENT_Y: ext_y <= cfg.data;
        REG_EXTENT_Z: ext_z <= cfg.data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // coefficient row in tap order
  assign coef_in[TAP_C] = items.coef_center;
  assign coef_in[TAP_W] = items.coef_west;
  assign coef_in[TAP_E] = items.coef_east;
  assign coef_in[TAP_S] = items.coef_south;
  assign coef_in[TAP_N] = items.coef_north;
  assign coef_in[TAP_B] = items.coef_bottom;
  assign coef_in[TAP_T] = items.coef_top;

  sp7_ctrl #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z),
    .AW     (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (items.valid),
    .item_action (items.action),
    .item_x      (items.cell_x),
    .item_y      (items.cell_y),
    .item_z      (items.cell_z),
    .ext_x       (ext_x),
    .ext_y       (ext_y),
    .ext_z       (ext_z),
    .out_free    (out_free),
    .item_ready  (items.ready),
    .ram_req     (ram_req),
    .ram_addr    (ram_addr),
    .mac_ctl     (mac_ctl),
    .result_load (result_load)
  );

  // grid store, written by loads, read by the tap walk
  sp7_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_addr),
    .wdata (items.vector_value),
    .rdata (ram_rdata)
  );

  sp7_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .mac_ctl (mac_ctl),
    .coef_in (coef_in),
    .rdata   (ram_rdata),
    .sum_sat (sum_sat)
  );

  // output register: one result beat held until taken
  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_value <= sum_sat;
    end
  end

  assign results.valid         = out_valid;
  assign results.product_value = out_value;

  // single RAM port: never a read and a write in the same cycle
  a_ram_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("grid RAM read and write in the same cycle");

  // a load beat never produces a result beat
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && !items.action && !results.valid)
    |=> !results.valid)
    else $error("result beat after a load");

  // a compute beat holds off further input while the taps are walked
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.action) |=> !items.ready)
    else $error("input taken during a compute");

  // RAM reads only while a compute is in flight
  a_read_in_compute: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |-> !items.ready)
    else $error("grid read outside a compute");

endmodule

// File: rtl/sp7_ram.sv
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module sp7_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/sp7_ctrl.sv
// Sequencer: takes items, writes loads, walks the seven stencil taps on the
// single RAM port and hands the result over. Depends on sp7_pkg.
module sp7_ctrl import sp7_pkg::*; #(
  parameter int GRID_X = GRID_X_DEFAULT,
  parameter int GRID_Y = GRID_Y_DEFAULT,
  parameter int GRID_Z = GRID_Z_DEFAULT,
  parameter int AW     = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_action,
  input  logic [COORD_W-1:0]  item_x,
  input  logic [COORD_W-1:0]  item_y,
  input  logic [COORD_W-1:0]  item_z,
  input  logic [EXTENT_W-1:0] ext_x,
  input  logic [EXTENT_W-1:0] ext_y,
  input  logic [EXTENT_W-1:0] ext_z,
  input  logic                out_free,
  output logic                item_ready,
  output ram_req_t            ram_req,
  output logic [AW-1:0]       ram_addr,
  output mac_ctl_t            mac_ctl,
  output logic                result_load
);

  localparam int NW = COORD_W + 1;  // neighbor coordinate, may reach 16 or -1

  function automatic logic [EXTENT_W-1:0] eff_ext(input logic [EXTENT_W-1:0] r,
                                                  input int lim);
    logic [EXTENT_W-1:0] e;
    if (r == '0) e = EXTENT_W'(1);
    else if (32'(r) > lim) e = EXTENT_W'(lim);
    else e = r;
    return e;
  endfunction

  st_e                 st, st_next;
  tap_e                tap, tap_next;
  logic [1:0]          drain, drain_next;
  logic [COORD_W-1:0]  cx, cy, cz;
  logic [TAPS-1:0]     en;
  logic [TAPS-1:0]     en_new;
  logic [EXTENT_W-1:0] ex, ey, ez;
  logic                accept, in_ext, load_ok;
  logic [NW-1:0]       nx, ny, nz;
  logic [AW-1:0]       addr_rd, addr_ld;

  assign ex = eff_ext(ext_x, GRID_X);
  assign ey = eff_ext(ext_y, GRID_Y);
  assign ez = eff_ext(ext_z, GRID_Z);

  assign item_ready = (st == ST_IDLE);
  assign accept     = item_valid && item_ready;

  // tap enables of a new compute item
  always_comb begin
    in_ext = (EXTENT_W'(item_x) < ex) && (EXTENT_W'(item_y) < ey) &&
             (EXTENT_W'(item_z) < ez);
    en_new[TAP_C] = in_ext;
    en_new[TAP_W] = in_ext && (item_x != '0);
    en_new[TAP_E] = in_ext && ((EXTENT_W'(item_x) + EXTENT_W'(1)) < ex);
    en_new[TAP_S] = in_ext && (item_y != '0);
    en_new[TAP_N] = in_ext && ((EXTENT_W'(item_y) + EXTENT_W'(1)) < ey);
    en_new[TAP_B] = in_ext && (item_z != '0);
    en_new[TAP_T] = in_ext && ((EXTENT_W'(item_z) + EXTENT_W'(1)) < ez);
  end

  // loads outside the store are dropped
  assign load_ok = (32'(item_x) < GRID_X) && (32'(item_y) < GRID_Y) &&
                   (32'(item_z) < GRID_Z);
  assign addr_ld = AW'((32'(item_z) * GRID_Y + 32'(item_y)) * GRID_X + 32'(item_x));

  // neighbor coordinates of the current tap
  always_comb begin
    nx = NW'(cx);
    ny = NW'(cy);
    nz = NW'(cz);
    case (tap)
      TAP_W:   nx = NW'(cx) - NW'(1);
      TAP_E:   nx = NW'(cx) + NW'(1);
      TAP_S:   ny = NW'(cy) - NW'(1);
      TAP_N:   ny = NW'(cy) + NW'(1);
      TAP_B:   nz = NW'(cz) - NW'(1);
      TAP_T:   nz = NW'(cz) + NW'(1);
      default: ;
    endcase
  end
  assign addr_rd = AW'((32'(nz) * GRID_Y + 32'(ny)) * GRID_X + 32'(nx));

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      tap   <= TAP_C;
      drain <= '0;
      en    <= '0;
    end else begin
      st    <= st_next;
      tap   <= tap_next;
      drain <= drain_next;
      if (accept && item_action) begin
        en <= en_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item_action) begin
      cx <= item_x;
      cy <= item_y;
      cz <= item_z;
    end
  end

  always_comb begin
    st_next     = st;
    tap_next    = tap;
    drain_next  = drain;
    result_load = 1'b0;
    ram_req.we  = 1'b0;
    ram_req.re  = 1'b0;
    ram_addr    = addr_ld;
    mac_ctl.clear     = 1'b0;
    mac_ctl.capture   = 1'b0;
    mac_ctl.tap_valid = 1'b0;
    mac_ctl.tap_sel   = tap;
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          if (item_action) begin
            mac_ctl.clear   = 1'b1;
            mac_ctl.capture = 1'b1;
            tap_next        = TAP_C;
            st_next         = ST_RUN;
          end else begin
            ram_req.we = load_ok;
          end
        end
      end
      ST_RUN: begin
        ram_addr          = addr_rd;
        ram_req.re        = en[tap];
        mac_ctl.tap_valid = en[tap];
        if (tap == TAP_T) begin
          drain_next = '0;
          st_next    = ST_DRAIN;
        end else begin
          tap_next = tap_e'(tap + 3'd1);
        end
      end
      ST_DRAIN: begin
        if (32'(drain) == DRAIN_CYCLES - 1) begin
          st_next = ST_DONE;
        end else begin
          drain_next = drain + 2'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          result_load = 1'b1;
          st_next     = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/sp7_mac.sv
// Multiply-round-accumulate pipeline for the stencil taps plus saturation.
// Depends on sp7_pkg.
module sp7_mac import sp7_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctl_t                  mac_ctl,
  input  logic signed [VALUE_W-1:0] coef_in [TAPS],
  input  logic        [VALUE_W-1:0] rdata,
  output logic signed [VALUE_W-1:0] sum_sat
);

  logic signed [VALUE_W-1:0] coef [TAPS];
  logic signed [VALUE_W-1:0] coef_pick;
  logic                      v1, v2, v3;
  tap_e                      sel1;
  logic signed [ACC_W-1:0]   prod, term, acc;

  always_ff @(posedge clk) begin
    if (mac_ctl.capture) begin
      coef <= coef_in;
    end
  end

  always_comb begin
    case (sel1)
      TAP_C:   coef_pick = coef[TAP_C];
      TAP_W:   coef_pick = coef[TAP_W];
      TAP_E:   coef_pick = coef[TAP_E];
      TAP_S:   coef_pick = coef[TAP_S];
      TAP_N:   coef_pick = coef[TAP_N];
      TAP_B:   coef_pick = coef[TAP_B];
      TAP_T:   coef_pick = coef[TAP_T];
      default: coef_pick = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      sel1 <= TAP_C;
      acc  <= '0;
    end else begin
      v1   <= mac_ctl.tap_valid;
      sel1 <= mac_ctl.tap_sel;
      v2   <= v1;
      v3   <= v2;
      if (mac_ctl.clear) begin
        acc <= '0;
      end else if (v3) begin
        acc <= acc + term;
      end
    end
  end

  // round half up to Q.16: add half an lsb, floor shift
  always_ff @(posedge clk) begin
    prod <= ACC_W'($signed(rdata)) * ACC_W'(coef_pick);
    term <= (prod + ACC_W'(64'sd32768)) >>> FRAC_W;
  end

  always_comb begin
    if (acc > ACC_W'(64'sd2147483647)) begin
      sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (acc < -ACC_W'(64'sd2147483648)) begin
      sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sum_sat = acc[VALUE_W-1:0];
    end
  end

endmodule
